// ----- hw/rtl/dpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descent phase detector package
// Shared widths, register defaults, register indexes and phase codes.
// ----------------------------------------------------------------------------
package dpd_pkg;

    // field widths
    localparam int PA_W     = 17;
    localparam int THR_W    = 12;
    localparam int PAUSE_W  = 8;
    localparam int LAND_W   = 16;
    localparam int CNT16_W  = 16;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 56;

    // default window length
    localparam int WINDOW_LEN_DEF = 10;

    // register reset values
    localparam logic [THR_W-1:0]   DESCENT_THR_RST = 12'd30;
    localparam logic [THR_W-1:0]   STABLE_BAND_RST = 12'd5;
    localparam logic [PAUSE_W-1:0] PAUSE_COUNT_RST = 8'd5;
    localparam logic [LAND_W-1:0]  LAND_COUNT_RST  = 16'd60;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_BAND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAND_COUNT  = 2'd3;

    // flight phases
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_ARMED  = 3'd1,
        PH_DESC   = 3'd2,
        PH_PAUSED = 3'd3,
        PH_LANDED = 3'd4
    } phase_t;

endpackage

// ----- hw/rtl/descent_phase_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descent phase detector
// Moving-average barometer window with an idle/armed/descending/paused/landed
// phase tracker, one result word per sample word.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample word: pressure in pascals and the button level.
//   m_* returns one result word per sample: phase, floored window average,
//   record flag, record sequence number and the stability counter.
//   cfg_* writes the four thresholds; write only while the block is idle.
// Sequence:
//   Each sample goes in order through the window read/sum state, three
//   passes through the shared multiplier for the cross-multiplied compares,
//   the decide state, the bit-serial restoring divider for the average of
//   the SUM_W-bit sum, where SUM_W = 17 + clog2(WINDOW_LEN + 1), and the
//   output load. s_tready is high only while the sequencer is idle, one
//   sample in flight at a time, so a new sample is not taken until the
//   last one has been loaded into the output register.
// Reset:
//   Phase idle, window empty, thresholds at their defaults. No clearing
//   pass: the value read from an unwritten window slot is never used.
// Stall:
//   The result sits in an output register; a new sample is accepted while
//   it waits, and the finished next result holds until m_tready frees it.
// ----------------------------------------------------------------------------
module descent_phase_detector #(
    parameter int WINDOW_LEN = dpd_pkg::WINDOW_LEN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample in: [16:0] pressure_pa, [17] button_level, [23:18] zero
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dpd_pkg::S_TDATA_W-1:0]    s_tdata,
    // result out: [2:0] phase, [19:3] average_pa, [20] record_valid,
    // [36:21] record_seq, [52:37] stable_ticks, [55:53] zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dpd_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int PA_W    = dpd_pkg::PA_W;
    localparam int SLOT_W  = $clog2(WINDOW_LEN);
    localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W   = PA_W + CNT_W;
    localparam int DIV_W   = $clog2(SUM_W + 1);
    localparam int C16_W   = dpd_pkg::CNT16_W;
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW_LEN);
    localparam logic [DIV_W-1:0] DIV_STEPS = DIV_W'(SUM_W);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MUL_P, S_MUL_T, S_MUL_B, S_DECIDE, S_DIV, S_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [dpd_pkg::THR_W-1:0]   descent_thr_reg;
    logic [dpd_pkg::THR_W-1:0]   stable_band_reg;
    logic [dpd_pkg::PAUSE_W-1:0] pause_count_reg;
    logic [dpd_pkg::LAND_W-1:0]  land_count_reg;

    // window memory
    logic [PA_W-1:0] window_mem [WINDOW_LEN];
    logic [PA_W-1:0] old_sample_reg;

    // block state
    logic [SLOT_W-1:0]     slot_reg;
    logic                  full_reg;
    logic [SUM_W-1:0]      sum_reg;
    dpd_pkg::phase_t       phase_reg;
    logic [C16_W-1:0]      stable_reg;
    logic [PA_W-1:0]       baseline_reg;
    logic                  prev_btn_reg;
    logic [C16_W-1:0]      seq_reg;

    // per-sample working registers
    logic [PA_W-1:0]       sample_reg;
    logic                  btn_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [SUM_W-1:0]      pc_reg;
    logic [SUM_W-1:0]      tc_reg;
    logic [SUM_W-1:0]      bc_reg;
    logic [SUM_W-1:0]      quo_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      div_cnt_reg;
    logic                  rec_valid_reg;
    logic [C16_W-1:0]      rec_seq_reg;

    // output register
    logic                        m_tvalid_reg;
    logic [dpd_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                        out_load;

    logic s_acc;
    assign s_acc     = s_tvalid && (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // window update
    logic [CNT_W-1:0] slot_inc;
    logic             wrap;
    logic [SUM_W-1:0] sum_next;
    assign slot_inc = CNT_W'(slot_reg) + CNT_W'(1);
    assign wrap     = (slot_inc == WIN_CNT);
    assign sum_next = sum_reg - (full_reg ? SUM_W'(old_sample_reg) : SUM_W'(0))
                      + SUM_W'(sample_reg);

    // shared multiplier: operand times fill count
    logic [PA_W-1:0]  mul_a;
    logic [SUM_W-1:0] mul_p;
    always_comb
    begin
        case (state_reg)
            S_MUL_T: mul_a = PA_W'(descent_thr_reg);
            S_MUL_B: mul_a = PA_W'(stable_band_reg);
            default: mul_a = sample_reg;
        endcase
    end
    assign mul_p = SUM_W'(mul_a) * SUM_W'(count_reg);

    // divider step
    logic [CNT_W:0] trial;
    logic           take;
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign take  = (trial >= {1'b0, count_reg});

    // phase decision
    logic                   btn_fall;
    dpd_pkg::phase_t        ph1;
    logic [C16_W-1:0]       cnt1;
    logic [C16_W-1:0]       seq1;
    logic [PA_W-1:0]        base1;
    dpd_pkg::phase_t        phase_next;
    logic [C16_W-1:0]       stable_next;
    logic [C16_W-1:0]       cnt_inc;
    logic signed [SUM_W:0]  dev;
    logic signed [SUM_W:0]  mag;
    logic signed [PA_W:0]   rise;

    always_comb
    begin
        btn_fall = prev_btn_reg && !btn_reg;
        ph1   = phase_reg;
        cnt1  = stable_reg;
        seq1  = seq_reg;
        base1 = baseline_reg;
        if (btn_fall)
        begin
            if (phase_reg == dpd_pkg::PH_IDLE)
            begin
                ph1   = dpd_pkg::PH_ARMED;
                cnt1  = '0;
                seq1  = '0;
                base1 = sample_reg;
            end
            else if (phase_reg != dpd_pkg::PH_LANDED)
            begin
                ph1 = dpd_pkg::PH_IDLE;
            end
        end

        dev     = $signed({1'b0, pc_reg}) - $signed({1'b0, sum_reg});
        mag     = dev[SUM_W] ? -dev : dev;
        rise    = $signed({1'b0, sample_reg}) - $signed({1'b0, base1});
        cnt_inc = cnt1 + C16_W'(1);

        phase_next  = ph1;
        stable_next = cnt1;
        unique case (ph1)
            dpd_pkg::PH_ARMED:
            begin
                if (rise > $signed({1'b0, PA_W'(descent_thr_reg)}))
                begin
                    phase_next  = dpd_pkg::PH_DESC;
                    stable_next = '0;
                end
            end
            dpd_pkg::PH_DESC:
            begin
                if (mag < $signed({1'b0, bc_reg}))
                begin
                    stable_next = cnt_inc;
                    if (cnt_inc == C16_W'(pause_count_reg))
                    begin
                        phase_next  = dpd_pkg::PH_PAUSED;
                        stable_next = '0;
                    end
                end
                else
                begin
                    stable_next = '0;
                end
            end
            dpd_pkg::PH_PAUSED:
            begin
                if (dev > $signed({1'b0, tc_reg}))
                begin
                    phase_next  = dpd_pkg::PH_DESC;
                    stable_next = '0;
                end
                else
                begin
                    stable_next = cnt_inc;
                    if (cnt_inc >= land_count_reg)
                        phase_next = dpd_pkg::PH_LANDED;
                end
            end
            default:
            begin
                phase_next = dpd_pkg::PH_IDLE;
            end
        endcase
    end

    // window memory: registered read at accept, write after the read
    always_ff @(posedge clk)
    begin
        if (s_acc)
            old_sample_reg <= window_mem[slot_reg];
        if (state_reg == S_READ)
            window_mem[slot_reg] <= sample_reg;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descent_thr_reg <= dpd_pkg::DESCENT_THR_RST;
            stable_band_reg <= dpd_pkg::STABLE_BAND_RST;
            pause_count_reg <= dpd_pkg::PAUSE_COUNT_RST;
            land_count_reg  <= dpd_pkg::LAND_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dpd_pkg::CFG_DESCENT_THR: descent_thr_reg <= cfg_data[dpd_pkg::THR_W-1:0];
                dpd_pkg::CFG_STABLE_BAND: stable_band_reg <= cfg_data[dpd_pkg::THR_W-1:0];
                dpd_pkg::CFG_PAUSE_COUNT: pause_count_reg <= cfg_data[dpd_pkg::PAUSE_W-1:0];
                dpd_pkg::CFG_LAND_COUNT:  land_count_reg  <= cfg_data[dpd_pkg::LAND_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            phase_reg     <= dpd_pkg::PH_IDLE;
            stable_reg    <= '0;
            baseline_reg  <= '0;
            prev_btn_reg  <= 1'b1;
            seq_reg       <= '0;
            sample_reg    <= '0;
            btn_reg       <= 1'b1;
            count_reg     <= '0;
            pc_reg        <= '0;
            tc_reg        <= '0;
            bc_reg        <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
            rec_valid_reg <= 1'b0;
            rec_seq_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            // output register: load a finished word, drop it once taken
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        sample_reg <= s_tdata[PA_W-1:0];
                        btn_reg    <= s_tdata[PA_W];
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                begin
                    sum_reg   <= sum_next;
                    slot_reg  <= wrap ? '0 : slot_inc[SLOT_W-1:0];
                    full_reg  <= full_reg || wrap;
                    count_reg <= (full_reg || wrap) ? WIN_CNT : slot_inc;
                    state_reg <= S_MUL_P;
                end
                S_MUL_P:
                begin
                    pc_reg    <= mul_p;
                    state_reg <= S_MUL_T;
                end
                S_MUL_T:
                begin
                    tc_reg    <= mul_p;
                    state_reg <= S_MUL_B;
                end
                S_MUL_B:
                begin
                    bc_reg    <= mul_p;
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    phase_reg    <= phase_next;
                    stable_reg   <= stable_next;
                    baseline_reg <= base1;
                    prev_btn_reg <= btn_reg;
                    if (phase_next != dpd_pkg::PH_IDLE)
                    begin
                        rec_valid_reg <= 1'b1;
                        rec_seq_reg   <= seq1;
                        seq_reg       <= seq1 + C16_W'(1);
                    end
                    else
                    begin
                        rec_valid_reg <= 1'b0;
                        rec_seq_reg   <= '0;
                        seq_reg       <= seq1;
                    end
                    quo_reg     <= sum_reg;
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg     <= take ? CNT_W'(trial - {1'b0, count_reg})
                                        : trial[CNT_W-1:0];
                    quo_reg     <= {quo_reg[SUM_W-2:0], take};
                    div_cnt_reg <= div_cnt_reg + DIV_W'(1);
                    if (div_cnt_reg == DIV_STEPS - DIV_W'(1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg  <= {3'b000, stable_reg, rec_seq_reg, rec_valid_reg,
                                         quo_reg[PA_W-1:0], phase_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/sv/descent_phase_detector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descent phase detector testbench
// Streams barometer words through the detector and checks every result word
// against an in-bench model of the window average and the phase tracker.
// A short table walks reset values, pressure extremes, arming, disarming,
// pause, landing and a press while landed. Random flights follow: pad time,
// arm, climb in pressure, a settling stretch, with register sets that include
// the extremes, random gaps on the sample side and stalls on the result side.
// ----------------------------------------------------------------------------
module descent_phase_detector_tb;

    localparam int PA_W         = dpd_pkg::PA_W;
    localparam int THR_W        = dpd_pkg::THR_W;
    localparam int PAUSE_W      = dpd_pkg::PAUSE_W;
    localparam int LAND_W       = dpd_pkg::LAND_W;
    localparam int CNT16_W      = dpd_pkg::CNT16_W;
    localparam int CFG_IDX_W    = dpd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = dpd_pkg::CFG_DATA_W;
    localparam int S_TDATA_W    = dpd_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = dpd_pkg::M_TDATA_W;
    localparam int WLEN         = dpd_pkg::WINDOW_LEN_DEF;
    localparam int PA_MAX       = (1 << PA_W) - 1;
    localparam int ITEMS_TARGET = 1350;
    localparam int QUIET_ITEMS  = 400;

    // one result word, split into its fields
    typedef struct packed {
        dpd_pkg::phase_t      phase;
        logic [PA_W-1:0]      avg_pa;
        logic                 rec_valid;
        logic [CNT16_W-1:0]   rec_seq;
        logic [CNT16_W-1:0]   steady;
    } record_t;

    localparam record_t NO_REC = '0;

    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [PA_W-1:0]       pa;
        logic                  button;
        logic                  typed;
        record_t               want;
    } stim_row_t;

    // directed walk; typed rows carry their own expected word
    localparam stim_row_t DIRECTED [29] = '{
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd131071, 1'b1, 1'b1,
          '{dpd_pkg::PH_IDLE, 17'd131071, 1'b0, 16'd0, 16'd0}},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd0, 1'b1, 1'b1,
          '{dpd_pkg::PH_IDLE, 17'd65535, 1'b0, 16'd0, 16'd0}},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100000, 1'b0, 1'b1,
          '{dpd_pkg::PH_ARMED, 17'd77023, 1'b1, 16'd0, 16'd0}},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100000, 1'b0, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100000, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100000, 1'b0, 1'b1,
          '{dpd_pkg::PH_IDLE, 17'd88511, 1'b0, 16'd0, 16'd0}},
        // wide band, pause after one steady word, land at once
        '{ROW_REG, dpd_pkg::CFG_STABLE_BAND, 16'd4095, 17'd0, 1'b1, 1'b0, NO_REC},
        '{ROW_REG, dpd_pkg::CFG_PAUSE_COUNT, 16'd1, 17'd0, 1'b1, 1'b0, NO_REC},
        '{ROW_REG, dpd_pkg::CFG_LAND_COUNT, 16'd0, 17'd0, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100000, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100000, 1'b0, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100031, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100031, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100031, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100031, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100031, 1'b1, 1'b0, NO_REC},
        // press while landed
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100031, 1'b0, 1'b0, NO_REC},
        '{ROW_REG, dpd_pkg::CFG_LAND_COUNT, 16'd3, 17'd0, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100031, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100031, 1'b0, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100100, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd100100, 1'b1, 1'b0, NO_REC},
        // jump while paused, then disarm while descending
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd101000, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd101000, 1'b0, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd101000, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd101000, 1'b0, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd101100, 1'b1, 1'b0, NO_REC},
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd101100, 1'b1, 1'b0, NO_REC},
        // disarm while paused
        '{ROW_SAMPLE, dpd_pkg::CFG_DESCENT_THR, 16'd0, 17'd101100, 1'b0, 1'b0, NO_REC}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = dpd_pkg::CFG_DESCENT_THR;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // bench model state
    logic [THR_W-1:0]      thr_descent = dpd_pkg::DESCENT_THR_RST;
    logic [THR_W-1:0]      band_stable = dpd_pkg::STABLE_BAND_RST;
    logic [PAUSE_W-1:0]    pause_limit = dpd_pkg::PAUSE_COUNT_RST;
    logic [LAND_W-1:0]     land_limit  = dpd_pkg::LAND_COUNT_RST;
    logic [PA_W-1:0]       win_samples [WLEN];
    int                    win_slot = 0;
    bit                    win_full = 1'b0;
    int unsigned           win_sum = 0;
    dpd_pkg::phase_t       cur_phase = dpd_pkg::PH_IDLE;
    logic [CNT16_W-1:0]    steady_cnt = '0;
    logic [PA_W-1:0]       launch_base = '0;
    logic                  last_button = 1'b1;
    logic [CNT16_W-1:0]    seq_next = '0;

    record_t               records_due [$];
    record_t               seen;
    record_t               want_rec;
    int                    bad_words = 0;
    int                    samples_sent = 0;
    int                    stall_left = 0;
    bit                    gaps_on = 1'b0;
    bit                    stalls_on = 1'b0;

    descent_phase_detector #(
        .WINDOW_LEN (WLEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one sample through the window and the phase tracker
    function automatic record_t advance_detector(input logic [PA_W-1:0] pa,
                                                 input logic button);
        longint  cnt;
        longint  dev;
        longint  mag;
        record_t r;
        if (win_full)
            win_sum = win_sum - win_samples[win_slot];
        win_samples[win_slot] = pa;
        win_sum = win_sum + pa;
        if (win_slot == WLEN - 1)
        begin
            win_slot = 0;
            win_full = 1'b1;
        end
        else
            win_slot = win_slot + 1;
        cnt = win_full ? longint'(WLEN) : longint'(win_slot);

        // falling edge of the button arms or disarms
        if (last_button && !button)
        begin
            if (cur_phase == dpd_pkg::PH_IDLE)
            begin
                cur_phase   = dpd_pkg::PH_ARMED;
                seq_next    = '0;
                steady_cnt  = '0;
                launch_base = pa;
            end
            else if (cur_phase != dpd_pkg::PH_LANDED)
                cur_phase = dpd_pkg::PH_IDLE;
        end
        last_button = button;

        dev = longint'(pa) * cnt - longint'(win_sum);
        case (cur_phase)
            dpd_pkg::PH_ARMED:
            begin
                if (longint'(pa) - longint'(launch_base) > longint'(thr_descent))
                begin
                    cur_phase  = dpd_pkg::PH_DESC;
                    steady_cnt = '0;
                end
            end
            dpd_pkg::PH_DESC:
            begin
                mag = (dev < 0) ? -dev : dev;
                if (mag < longint'(band_stable) * cnt)
                begin
                    steady_cnt = steady_cnt + 1'b1;
                    if (steady_cnt == CNT16_W'(pause_limit))
                    begin
                        cur_phase  = dpd_pkg::PH_PAUSED;
                        steady_cnt = '0;
                    end
                end
                else
                    steady_cnt = '0;
            end
            dpd_pkg::PH_PAUSED:
            begin
                if (dev > longint'(thr_descent) * cnt)
                begin
                    cur_phase  = dpd_pkg::PH_DESC;
                    steady_cnt = '0;
                end
                else
                begin
                    steady_cnt = steady_cnt + 1'b1;
                    if (steady_cnt >= land_limit)
                        cur_phase = dpd_pkg::PH_LANDED;
                end
            end
            default:
                cur_phase = dpd_pkg::PH_IDLE;
        endcase

        r.phase  = cur_phase;
        r.avg_pa = PA_W'(longint'(win_sum) / cnt);
        if (cur_phase != dpd_pkg::PH_IDLE)
        begin
            r.rec_valid = 1'b1;
            r.rec_seq   = seq_next;
            seq_next    = seq_next + 1'b1;
        end
        else
        begin
            r.rec_valid = 1'b0;
            r.rec_seq   = '0;
        end
        r.steady = steady_cnt;
        return r;
    endfunction

    function automatic string rec_text(input record_t r);
        return $sformatf("phase=%0d avg=%0d valid=%0b seq=%0d stable=%0d",
                         r.phase, r.avg_pa, r.rec_valid, r.rec_seq, r.steady);
    endfunction

    function automatic logic [PA_W-1:0] clamp_pa(input int v);
        if (v < 0)
            return '0;
        if (v > PA_MAX)
            return PA_MAX[PA_W-1:0];
        return PA_W'(v);
    endfunction

    function automatic int jitter(input int v, input int w);
        return v + int'($urandom_range(0, 2 * w)) - w;
    endfunction

    // button during flight: held down, or released with a rare stray press
    function automatic logic flight_button(input bit hold);
        if (hold)
            return 1'b0;
        return ($urandom_range(0, 49) == 0) ? 1'b0 : 1'b1;
    endfunction

    task automatic send_sample(input logic [PA_W-1:0] pa, input logic button,
                               input logic typed = 1'b0, input record_t want = NO_REC);
        record_t predicted;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - PA_W - 1){1'b0}}, button, pa};
        do @(posedge clk); while (!s_tready);
        predicted = advance_detector(pa, button);
        records_due.push_back(typed ? want : predicted);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            dpd_pkg::CFG_DESCENT_THR: thr_descent = val[THR_W-1:0];
            dpd_pkg::CFG_STABLE_BAND: band_stable = val[THR_W-1:0];
            dpd_pkg::CFG_PAUSE_COUNT: pause_limit = val[PAUSE_W-1:0];
            dpd_pkg::CFG_LAND_COUNT:  land_limit  = val[LAND_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // stop sending and wait for every result in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (records_due.size() != 0);
    endtask

    // new register set; some sets sit at the ends of the ranges
    task automatic set_registers();
        logic [THR_W-1:0]   thr;
        logic [THR_W-1:0]   band;
        logic [PAUSE_W-1:0] pc;
        logic [LAND_W-1:0]  lc;
        bit                 junk;
        case ($urandom_range(0, 9))
            0:
            begin
                thr  = '0;
                band = '0;
                pc   = PAUSE_W'($urandom_range(0, 1));
                lc   = LAND_W'($urandom_range(0, 1));
            end
            1:
            begin
                thr  = '1;
                band = '1;
                pc   = '1;
                lc   = '1;
            end
            2:
            begin
                thr  = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
                band = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
                pc   = PAUSE_W'($urandom_range(1, 3));
                lc   = LAND_W'($urandom_range(0, 3));
            end
            default:
            begin
                thr  = THR_W'($urandom_range(1, 200));
                band = THR_W'($urandom_range(1, 60));
                pc   = PAUSE_W'($urandom_range(1, 8));
                lc   = LAND_W'($urandom_range(1, 25));
            end
        endcase
        // stray upper data bits now and then; the registers keep their width
        junk = ($urandom_range(0, 3) == 0);
        write_reg(dpd_pkg::CFG_DESCENT_THR, {(junk ? 4'($urandom) : 4'd0), thr});
        write_reg(dpd_pkg::CFG_STABLE_BAND, {(junk ? 4'($urandom) : 4'd0), band});
        write_reg(dpd_pkg::CFG_PAUSE_COUNT, {(junk ? 8'($urandom) : 8'd0), pc});
        write_reg(dpd_pkg::CFG_LAND_COUNT, lc);
    endtask

    // pad, arm, climb in pressure, settle, then a few words after
    task automatic fly_flight();
        int base;
        int lvl;
        int wob;
        int stay;
        int bump_at;
        bit hold;
        wob  = int'(band_stable) / 3;
        base = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, PA_MAX))
                                           : int'($urandom_range(80000, 125000));
        repeat ($urandom_range(1, 12)) send_sample(clamp_pa(jitter(base, wob)), 1'b1);

        // still flying from before: press to drop back, then release
        if (cur_phase != dpd_pkg::PH_IDLE)
        begin
            send_sample(clamp_pa(base), 1'b0);
            send_sample(clamp_pa(base), 1'b1);
        end

        hold = ($urandom_range(0, 3) == 0);
        send_sample(clamp_pa(base), 1'b0);
        lvl = base;
        repeat ($urandom_range(1, 6))
        begin
            lvl = lvl + int'(thr_descent) + int'($urandom_range(0, 40));
            send_sample(clamp_pa(lvl), flight_button(hold));
        end

        stay = 10 + int'(pause_limit) + int'(land_limit) + int'($urandom_range(0, 6));
        if (stay > 60)
            stay = 60;
        bump_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(15, stay)) : -1;
        for (int k = 0; k < stay; k++)
        begin
            if (k == bump_at)
                lvl = lvl + 2 * int'(thr_descent) + int'($urandom_range(5, 60));
            send_sample(clamp_pa(jitter(lvl, wob)), flight_button(hold));
        end

        repeat ($urandom_range(1, 3)) send_sample(clamp_pa(jitter(lvl, wob)), 1'b1);
    endtask

    // result side stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end
        else
            m_tready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.phase     = dpd_pkg::phase_t'(m_tdata[2:0]);
            seen.avg_pa    = m_tdata[19:3];
            seen.rec_valid = m_tdata[20];
            seen.rec_seq   = m_tdata[36:21];
            seen.steady    = m_tdata[52:37];
            if (records_due.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected result word: %s", rec_text(seen));
            end
            else
            begin
                want_rec = records_due.pop_front();
                if (seen.phase !== want_rec.phase || seen.avg_pa !== want_rec.avg_pa
                    || seen.rec_valid !== want_rec.rec_valid
                    || seen.rec_seq !== want_rec.rec_seq
                    || seen.steady !== want_rec.steady)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("mismatch at %0t: expected %s, got %s",
                                 $realtime, rec_text(want_rec), rec_text(seen));
                end
            end
        end
    end

    // main sequence
    initial
    begin
        bit quiet;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_REG)
            begin
                settle();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            end
            else
                send_sample(DIRECTED[i].pa, DIRECTED[i].button,
                            DIRECTED[i].typed, DIRECTED[i].want);
        end

        // random flights, one register set per round
        while (samples_sent < ITEMS_TARGET)
        begin
            settle();
            set_registers();
            quiet     = (samples_sent >= ITEMS_TARGET - QUIET_ITEMS);
            gaps_on   = !quiet && ($urandom_range(0, 3) != 0);
            stalls_on = !quiet && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 4))
                if (samples_sent < ITEMS_TARGET)
                    fly_flight();
            repeat ($urandom_range(0, 6))
                send_sample(PA_W'($urandom), 1'($urandom));
        end

        settle();
        repeat (40) @(posedge clk);
        if (bad_words == 0 && records_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dpd_pkg.sv
hw/rtl/descent_phase_detector.sv
tb/sv/descent_phase_detector_tb.sv
